// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every sampled edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent on the same edge.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/swgp_pkg.sv
// ---------------------------------------------------------------------------
// swgp_pkg
// Types, constants and the per-channel step function of the sweeping gap
// pulse generator.
// ---------------------------------------------------------------------------
package swgp_pkg;

  localparam int TIME_W  = 64;
  localparam int GAP_W   = 15;
  localparam int SPEED_W = 10;
  localparam int ADJ_W   = 12;  // floor(1023 * 5 / 2) = 2557
  localparam int PROD_W  = 13;  // 1023 * 5 = 5115
  localparam int MULT_W  = 3;   // channel multiplier n + 2, up to 5
  localparam int MASK_W  = 4;
  localparam int SUM_W   = GAP_W + 1;

  localparam logic [GAP_W-1:0]   GAP_MIN_US  = 15'd2700;
  localparam logic [GAP_W-1:0]   GAP_MAX_US  = 15'd32000;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd200;

  // One time sample as seen by every channel.
  typedef struct packed {
    logic              go;
    logic [TIME_W-1:0] now_us;
  } swgp_tick_t;

  // floor(speed * mult / 2)
  function automatic logic [ADJ_W-1:0] chan_adj(input logic [SPEED_W-1:0] speed,
                                                input logic [MULT_W-1:0]  mult);
    logic [PROD_W-1:0] prod;
    prod = {{(PROD_W-SPEED_W){1'b0}}, speed} * {{(PROD_W-MULT_W){1'b0}}, mult};
    return prod[PROD_W-1:1];
  endfunction

endpackage

// File: rtl/core/swgp_chan.sv
// ---------------------------------------------------------------------------
// swgp_chan
// One pulse channel: fire compare, gap sweep with clamp and turn-around,
// next-fire time update.
// ---------------------------------------------------------------------------
module swgp_chan import swgp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  swgp_tick_t       tick,
  input  logic [ADJ_W-1:0] adj,
  output logic             fire
);

  logic [GAP_W-1:0]  gap_r,  gap_nxt;
  logic              rising_r, rising_nxt;
  logic [TIME_W-1:0] next_fire_r, next_fire_nxt;

  logic [SUM_W-1:0]  sum_up;
  logic [SUM_W-1:0]  fall_lim;
  logic [GAP_W-1:0]  gap_new;
  logic              rising_new;

  assign fire = tick.go && (tick.now_us > next_fire_r);

  // New gap depends only on state, so it runs beside the 64-bit compare.
  assign sum_up   = {1'b0, gap_r} + SUM_W'(adj);
  assign fall_lim = SUM_W'(adj) + SUM_W'(GAP_MIN_US);

  always_comb begin
    gap_new    = gap_r;
    rising_new = rising_r;
    if (rising_r) begin
      if (sum_up > SUM_W'(GAP_MAX_US)) begin
        gap_new    = GAP_MAX_US;
        rising_new = 1'b0;
      end else begin
        gap_new = sum_up[GAP_W-1:0];
      end
    end else begin
      if ({1'b0, gap_r} < fall_lim) begin
        gap_new    = GAP_MIN_US;
        rising_new = 1'b1;
      end else begin
        gap_new = gap_r - GAP_W'(adj);
      end
    end
  end

  always_comb begin
    gap_nxt       = gap_r;
    rising_nxt    = rising_r;
    next_fire_nxt = next_fire_r;
    if (fire) begin
      gap_nxt       = gap_new;
      rising_nxt    = rising_new;
      next_fire_nxt = tick.now_us + TIME_W'(gap_new);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r       <= GAP_MAX_US;
      rising_r    <= 1'b1;
      next_fire_r <= '0;
    end else begin
      gap_r       <= gap_nxt;
      rising_r    <= rising_nxt;
      next_fire_r <= next_fire_nxt;
    end
  end

endmodule

// File: rtl/core/sweeping_gap_pulse_generator.sv
// Throughput: one item per cycle while out_ready drains results; the channel state
//   updates in the cycle the item leaves the input register, so the next item
//   already sees it. Rate is set by one 64-bit compare plus one 64-bit add
//   per channel in that cycle.
// Reset: synchronous, active low; speed = 200, every gap = 32000 rising,
//   every next-fire time = 0, both pipeline registers empty.
// ---------------------------------------------------------------------------
// sweeping_gap_pulse_generator
// Up to four pulse channels on a shared microsecond time base. Each channel
// fires when the time passes its next-fire time, then sweeps its gap between
// 2700 and 32000 by a per-channel step of speed * (n + 2) / 2.
// ---------------------------------------------------------------------------
module sweeping_gap_pulse_generator import swgp_pkg::*; #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: speed
  input  logic               cfg_wr_en,
  input  logic [SPEED_W-1:0] cfg_wr_data,
  // time samples in
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TIME_W-1:0]  in_now_us,
  // pulse masks out
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MASK_W-1:0]  out_pulse_mask
);

  logic [SPEED_W-1:0] speed_r, speed_nxt;

  // Input register: one time sample waiting for the channels.
  logic               s1_valid_r, s1_valid_nxt;
  logic [TIME_W-1:0]  s1_now_r,   s1_now_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]  out_mask_r,  out_mask_nxt;

  logic               s1_go;
  logic               in_take;
  swgp_tick_t         tick;
  logic [MASK_W-1:0]  fire_vec;

  // The sample moves on whenever the result register is empty or being drained;
  // that same cycle the input register frees up for the next item.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_take  = in_valid && in_ready;

  assign tick.go     = s1_go;
  assign tick.now_us = s1_now_r;

  // Channels side by side. Unused mask bits stay zero.
  for (genvar ch = 0; ch < MASK_W; ch++) begin : g_chan
    if (ch < NUM_CHANNELS) begin : g_on
      logic [ADJ_W-1:0] adj;
      assign adj = chan_adj(speed_r, MULT_W'(ch + 2));
      swgp_chan u_chan (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .adj   (adj),
        .fire  (fire_vec[ch])
      );
    end else begin : g_off
      assign fire_vec[ch] = 1'b0;
    end
  end

  always_comb begin
    speed_nxt     = cfg_wr_en ? cfg_wr_data : speed_r;
    s1_now_nxt    = in_take ? in_now_us : s1_now_r;
    s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_mask_nxt  = s1_go ? fire_vec : out_mask_r;
    out_valid_nxt = s1_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= SPEED_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      speed_r     <= speed_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    s1_now_r   <= s1_now_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pulse_mask = out_mask_r;

endmodule

// File: rtl/core/swgp_checker.sv
// ---------------------------------------------------------------------------
// swgp_checker
// Port-level checks of the pulse generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module swgp_checker import swgp_pkg::*; #(
  parameter int NUM_CHANNELS = 4
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [MASK_W-1:0]  out_pulse_mask
);

  logic [MASK_W-1:0] dead_bits;
  assign dead_bits = out_pulse_mask >> NUM_CHANNELS;

  // Channels that do not exist never fire.
  `ASSERT_SAME(a_dead_bits, clk, rst_n, out_valid, dead_bits == '0, "unused channel fired")

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pulse_mask), "stalled result changed")

  // With the result register empty the input side never stalls.
  `ASSERT_SAME(a_ready_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")

  // A fresh result follows an accepted item; no result appears without one.
  `ASSERT_SAME(a_no_phantom, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without item")

endmodule

bind sweeping_gap_pulse_generator swgp_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_swgp_checker (.*);
